[design/fts_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fts_pkg
// Types, sizes and codes shared by the thread scheduler modules.
// ----------------------------------------------------------------------------
package fts_pkg;

    localparam int MAX_THREADS = 16;
    localparam int MAX_SEMS    = 16;
    localparam int COUNT_BITS  = 16;

    localparam int THR_W  = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int SEM_W  = (MAX_SEMS > 1) ? $clog2(MAX_SEMS) : 1;
    localparam int FILL_W = $clog2(MAX_THREADS + 1);

    localparam logic [31:0] COUNT_MAX = 32'((64'd1 << COUNT_BITS) - 64'd1);

    typedef logic [THR_W-1:0]      thr_t;
    typedef logic [SEM_W-1:0]      sem_idx_t;
    typedef logic [FILL_W-1:0]     fill_t;
    typedef logic [COUNT_BITS-1:0] count_t;

    typedef enum logic [2:0] {
        ACT_INIT     = 3'd0,
        ACT_START    = 3'd1,
        ACT_YIELD    = 3'd2,
        ACT_FINISH   = 3'd3,
        ACT_SEMINIT  = 3'd4,
        ACT_SEMUP    = 3'd5,
        ACT_SEMDOWN  = 3'd6
    } action_e;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_INIT_ERR  = 3'd1,
        ST_NO_SEM    = 3'd2,
        ST_OVERFLOW  = 3'd3,
        ST_NO_RUN    = 3'd4
    } status_e;

    typedef struct packed {
        logic [2:0]  action;
        logic [3:0]  thread_id;
        logic [3:0]  sem_id;
        logic [15:0] init_value;
    } in_item_t;

    typedef struct packed {
        logic [2:0] status;
        logic       running_valid;
        logic [3:0] running_thread;
        logic       switched;
        logic       library_done;
    } out_item_t;

    // Ready queue control and status.
    typedef struct packed {
        logic push;
        thr_t push_thread;
        logic pop;
    } rq_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        thr_t head_thread;
    } rq_stat_t;

    // Semaphore table read data for the addressed semaphore.
    typedef struct packed {
        logic   present;
        count_t count;
        thr_t   first;
        thr_t   last;
        fill_t  fill;
        thr_t   first_link;
    } sem_rd_t;

    // Semaphore table writes for the addressed semaphore.
    typedef struct packed {
        logic   set_present;
        logic   count_we;
        count_t count;
        logic   first_we;
        thr_t   first;
        logic   last_we;
        thr_t   last;
        logic   fill_we;
        fill_t  fill;
        logic   link_we;
        thr_t   link_addr;
        thr_t   link_data;
    } sem_wr_t;

endpackage

[design/fts_ready_q.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fts_ready_q
// Circular FIFO of ready thread numbers with one push and one pop per cycle.
// ----------------------------------------------------------------------------
module fts_ready_q
    import fts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  rq_cmd_t  cmd,
    output rq_stat_t stat
);

    thr_t  store [MAX_THREADS];
    thr_t  head_reg;
    thr_t  head_next;
    thr_t  tail_reg;
    thr_t  tail_next;
    fill_t fill_reg;
    fill_t fill_next;

    assign stat.full        = (fill_reg == FILL_W'(MAX_THREADS));
    assign stat.empty       = (fill_reg == '0);
    assign stat.head_thread = store[head_reg];

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        if (cmd.push)
        begin
            tail_next = (tail_reg == THR_W'(MAX_THREADS - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (cmd.pop)
        begin
            head_next = (head_reg == THR_W'(MAX_THREADS - 1)) ? '0 : head_reg + 1'b1;
        end
        if (cmd.push && !cmd.pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (cmd.pop && !cmd.push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            store[tail_reg] <= cmd.push_thread;
        end
    end

endmodule

[design/fts_sem_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fts_sem_table
// Semaphore counts and linked FIFO wait queues, one semaphore per cycle.
// ----------------------------------------------------------------------------
module fts_sem_table
    import fts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  sem_idx_t idx,
    input  sem_wr_t  wr,
    output sem_rd_t  rd
);

    logic   present_reg [MAX_SEMS];
    fill_t  fill_reg    [MAX_SEMS];
    count_t count_mem   [MAX_SEMS];
    thr_t   first_mem   [MAX_SEMS];
    thr_t   last_mem    [MAX_SEMS];
    thr_t   link_mem    [MAX_THREADS];

    assign rd.present    = present_reg[idx];
    assign rd.count      = count_mem[idx];
    assign rd.first      = first_mem[idx];
    assign rd.last       = last_mem[idx];
    assign rd.fill       = fill_reg[idx];
    // The successor of the oldest waiter, needed when it leaves the queue.
    assign rd.first_link = link_mem[first_mem[idx]];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_SEMS; i++)
            begin
                present_reg[i] <= 1'b0;
                fill_reg[i]    <= '0;
            end
        end
        else
        begin
            if (wr.set_present)
            begin
                present_reg[idx] <= 1'b1;
            end
            if (wr.fill_we)
            begin
                fill_reg[idx] <= wr.fill;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.count_we)
        begin
            count_mem[idx] <= wr.count;
        end
        if (wr.first_we)
        begin
            first_mem[idx] <= wr.first;
        end
        if (wr.last_we)
        begin
            last_mem[idx] <= wr.last;
        end
        if (wr.link_we)
        begin
            link_mem[wr.link_addr] <= wr.link_data;
        end
    end

endmodule

[design/fts_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fts_ctrl
// Decodes one scheduler action and computes the result and all table writes.
// ----------------------------------------------------------------------------
module fts_ctrl
    import fts_pkg::*;
(
    input  logic      go,
    input  in_item_t  item,
    input  logic      started,
    input  logic      run_valid,
    input  thr_t      run_thread,
    input  rq_stat_t  rq_stat,
    input  sem_rd_t   sem_rd,
    output rq_cmd_t   rq_cmd,
    output sem_wr_t   sem_wr,
    output logic      started_next,
    output logic      run_valid_next,
    output thr_t      run_thread_next,
    output out_item_t result
);

    status_e status;
    logic    sw;
    logic    done;
    logic    tid_ok;
    logic    sid_ok;
    logic    sem_ok;
    thr_t    tid;
    rq_cmd_t rq_c;
    sem_wr_t sem_c;

    assign tid    = THR_W'(item.thread_id);
    assign tid_ok = (32'(item.thread_id) < 32'(MAX_THREADS));
    assign sid_ok = (32'(item.sem_id) < 32'(MAX_SEMS));
    assign sem_ok = sid_ok && sem_rd.present;

    always_comb
    begin
        status          = ST_OK;
        sw              = 1'b0;
        done            = 1'b0;
        started_next    = started;
        run_valid_next  = run_valid;
        run_thread_next = run_thread;
        rq_c            = '0;
        sem_c           = '0;

        case (action_e'(item.action))
            ACT_INIT:
            begin
                if (started)
                begin
                    status = ST_INIT_ERR;
                end
                else if (!tid_ok)
                begin
                    status = ST_OVERFLOW;
                end
                else
                begin
                    started_next    = 1'b1;
                    run_thread_next = tid;
                    run_valid_next  = 1'b1;
                    sw              = 1'b1;
                end
            end
            ACT_START:
            begin
                if (!started)
                begin
                    status = ST_INIT_ERR;
                end
                else if (!tid_ok || rq_stat.full)
                begin
                    status = ST_OVERFLOW;
                end
                else
                begin
                    rq_c.push        = 1'b1;
                    rq_c.push_thread = tid;
                end
            end
            ACT_YIELD:
            begin
                if (!run_valid)
                begin
                    status = ST_NO_RUN;
                end
                else if (rq_stat.full)
                begin
                    status = ST_OVERFLOW;
                end
                else
                begin
                    rq_c.push        = 1'b1;
                    rq_c.push_thread = run_thread;
                    rq_c.pop         = 1'b1;
                    // With an empty queue the yielding thread comes straight back.
                    run_thread_next  = rq_stat.empty ? run_thread : rq_stat.head_thread;
                    run_valid_next   = 1'b1;
                    sw               = 1'b1;
                end
            end
            ACT_FINISH:
            begin
                if (!run_valid)
                begin
                    status = ST_NO_RUN;
                end
                else if (!rq_stat.empty)
                begin
                    rq_c.pop        = 1'b1;
                    run_thread_next = rq_stat.head_thread;
                    sw              = 1'b1;
                end
                else
                begin
                    run_valid_next = 1'b0;
                    done           = 1'b1;
                end
            end
            ACT_SEMINIT:
            begin
                if (!started)
                begin
                    status = ST_INIT_ERR;
                end
                else if (!sid_ok)
                begin
                    status = ST_NO_SEM;
                end
                else if (!sem_rd.present)
                begin
                    sem_c.set_present = 1'b1;
                    sem_c.fill_we     = 1'b1;
                    sem_c.fill        = '0;
                    sem_c.count_we    = 1'b1;
                    if (32'(item.init_value) > COUNT_MAX)
                    begin
                        sem_c.count = COUNT_BITS'(COUNT_MAX);
                        status      = ST_OVERFLOW;
                    end
                    else
                    begin
                        sem_c.count = COUNT_BITS'(item.init_value);
                    end
                end
            end
            ACT_SEMUP:
            begin
                if (!sem_ok)
                begin
                    status = ST_NO_SEM;
                end
                else if (sem_rd.fill != '0)
                begin
                    if (rq_stat.full)
                    begin
                        status = ST_OVERFLOW;
                    end
                    else
                    begin
                        rq_c.push        = 1'b1;
                        rq_c.push_thread = sem_rd.first;
                        sem_c.first_we   = (sem_rd.fill > FILL_W'(1));
                        sem_c.first      = sem_rd.first_link;
                        sem_c.fill_we    = 1'b1;
                        sem_c.fill       = sem_rd.fill - 1'b1;
                    end
                end
                else if (32'(sem_rd.count) >= COUNT_MAX)
                begin
                    status = ST_OVERFLOW;
                end
                else
                begin
                    sem_c.count_we = 1'b1;
                    sem_c.count    = sem_rd.count + 1'b1;
                end
            end
            ACT_SEMDOWN:
            begin
                if (!sem_ok)
                begin
                    status = ST_NO_SEM;
                end
                else if (!run_valid)
                begin
                    status = ST_NO_RUN;
                end
                else if (sem_rd.count != '0)
                begin
                    sem_c.count_we = 1'b1;
                    sem_c.count    = sem_rd.count - 1'b1;
                end
                else if (sem_rd.fill >= FILL_W'(MAX_THREADS))
                begin
                    status = ST_OVERFLOW;
                end
                else
                begin
                    // Append the running thread to the wait list, then dispatch the next ready thread if any.
                    if (sem_rd.fill == '0)
                    begin
                        sem_c.first_we = 1'b1;
                        sem_c.first    = run_thread;
                    end
                    else
                    begin
                        sem_c.link_we   = 1'b1;
                        sem_c.link_addr = sem_rd.last;
                        sem_c.link_data = run_thread;
                    end
                    sem_c.last_we = 1'b1;
                    sem_c.last    = run_thread;
                    sem_c.fill_we = 1'b1;
                    sem_c.fill    = sem_rd.fill + 1'b1;
                    if (!rq_stat.empty)
                    begin
                        rq_c.pop        = 1'b1;
                        run_thread_next = rq_stat.head_thread;
                        sw              = 1'b1;
                    end
                    else
                    begin
                        run_valid_next = 1'b0;
                        done           = 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    assign rq_cmd = go ? rq_c : '0;
    assign sem_wr = go ? sem_c : '0;

    assign result.status         = status;
    assign result.running_valid  = run_valid_next;
    assign result.running_thread = run_valid_next ? 4'(run_thread_next) : 4'd0;
    assign result.switched       = sw;
    assign result.library_done   = done;

endmodule

[design/fifo_thread_scheduler_with_semaphores_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_thread_scheduler_with_semaphores_core
// Thread scheduler with a FIFO ready queue and counting semaphores.
// ----------------------------------------------------------------------------
// An action is held in an input register, decoded and applied to the ready
// queue and semaphore tables in one combined read-modify-write step, and its
// result is loaded into an output register. An accepted transaction waits in
// the input register while the output register holds an untaken result.
// One action per cycle is sustained while the result side keeps taking
// results; the combined table update is what sets that rate. No clearing
// pass is needed after reset.
module fifo_thread_scheduler_with_semaphores_core
    import fts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    in_item_t  in_reg;
    logic      in_valid_reg;
    out_item_t out_reg;
    logic      out_valid_reg;
    logic      started_reg;
    logic      started_next;
    logic      run_valid_reg;
    logic      run_valid_next;
    thr_t      run_thread_reg;
    thr_t      run_thread_next;
    logic      fire;
    rq_cmd_t   rq_cmd;
    rq_stat_t  rq_stat;
    sem_wr_t   sem_wr;
    sem_rd_t   sem_rd;
    out_item_t result;

    assign fire      = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !in_valid_reg || fire;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    fts_ready_q u_ready_q (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (rq_cmd),
        .stat  (rq_stat)
    );

    fts_sem_table u_sem_table (
        .clk   (clk),
        .rst_n (rst_n),
        .idx   (SEM_W'(in_reg.sem_id)),
        .wr    (sem_wr),
        .rd    (sem_rd)
    );

    fts_ctrl u_ctrl (
        .go              (fire),
        .item            (in_reg),
        .started         (started_reg),
        .run_valid       (run_valid_reg),
        .run_thread      (run_thread_reg),
        .rq_stat         (rq_stat),
        .sem_rd          (sem_rd),
        .rq_cmd          (rq_cmd),
        .sem_wr          (sem_wr),
        .started_next    (started_next),
        .run_valid_next  (run_valid_next),
        .run_thread_next (run_thread_next),
        .result          (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            started_reg    <= 1'b0;
            run_valid_reg  <= 1'b0;
            run_thread_reg <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (fire)
            begin
                in_valid_reg <= 1'b0;
            end

            if (fire)
            begin
                out_valid_reg  <= 1'b1;
                started_reg    <= started_next;
                run_valid_reg  <= run_valid_next;
                run_thread_reg <= run_thread_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_reg <= in_data;
        end
        if (fire)
        begin
            out_reg <= result;
        end
    end

    // A push is never issued into a full ready queue.
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        rq_cmd.push |-> !rq_stat.full)
        else $error("push into full ready queue");

    // A pop from an empty queue only happens together with a push (lone yield).
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        rq_cmd.pop |-> (!rq_stat.empty || rq_cmd.push))
        else $error("pop from empty ready queue");

    // A dispatch always leaves a thread running.
    a_switch_runs: assert property (@(posedge clk) disable iff (!rst_n)
        fire && result.switched |=> run_valid_reg && out_valid_reg)
        else $error("switch without a running thread");

    // Tables change only when an action is processed.
    a_quiet_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |-> !(rq_cmd.push || rq_cmd.pop || sem_wr.fill_we || sem_wr.count_we))
        else $error("table write without a transaction");

endmodule
